@@ rtl/cslru_pkg.sv @@
// ----------------------------------------------------------------------------
// Coordinate slot cache package
// Shared constants and payload types for the coordinate slot cache.
// ----------------------------------------------------------------------------
`default_nettype none

package cslru_pkg;

	localparam int SLOTS   = 512;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int COORD_W = 32;
	localparam int STAMP_W = 48;
	localparam int INDEX_W = 9;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic        [STAMP_W-1:0] frame_stamp;
	} in_t;

	typedef struct packed {
		logic [INDEX_W-1:0] slot_index;
		logic               newly_placed;
	} out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic        [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

endpackage

`default_nettype wire

@@ rtl/cslru_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cslru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/coordinate_slot_cache_lru_top.sv @@
// ----------------------------------------------------------------------------
// Coordinate slot cache with LRU replacement
// A request carries a signed 3D coordinate and a frame stamp. The block
// returns the slot holding that coordinate: an existing slot on a hit, with
// its stamp refreshed, or a newly claimed slot on a miss. A miss takes the
// lowest free slot, or else evicts the slot with the oldest stamp (lowest
// index on ties). Both channels use valid/ready; one request gives one
// result. Slot contents live in one memory with a registered read; slots are
// filled in index order and never freed, so a fill count marks which are
// in use. A request scans the slots in use one read per cycle, as the memory
// has a single read port, and stops at a hit. One request is processed at a
// time. The result sits in an output register, so a new request is taken
// while the previous result waits; a second result waits in the write state
// until the register is free. Reset empties the cache at once with no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module coordinate_slot_cache_lru_top
	import cslru_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	state_t             state_q;
	logic [CNT_W-1:0]   addr_q;
	logic [CNT_W-1:0]   fill_q;
	logic               rd_v_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [IDX_W-1:0]   old_idx_q;
	logic [STAMP_W-1:0] old_stamp_q;
	in_t                req_q;
	logic               out_valid_q;
	out_t               out_data_q;

	entry_t             rd_entry;
	entry_t             wr_entry;
	logic [ENTRY_W-1:0] rd_word;
	logic               issue;
	logic               match;
	logic               scan_done;
	logic               has_free;
	logic               write_go;
	logic [IDX_W-1:0]   target;

	assign rd_entry = entry_t'(rd_word);
	assign issue    = (state_q == ST_SCAN) && (addr_q != fill_q) && !hit_q;
	assign match    = rd_v_s1
		&& (rd_entry.coord_x == req_q.coord_x)
		&& (rd_entry.coord_y == req_q.coord_y)
		&& (rd_entry.coord_z == req_q.coord_z);
	assign scan_done = (state_q == ST_SCAN) && ((addr_q == fill_q) || hit_q) && !rd_v_s1;
	assign has_free  = (fill_q != CNT_W'(SLOTS));
	assign write_go  = (state_q == ST_WRITE) && (!out_valid_q || out_ready);

	always_comb begin
		if (hit_q) begin
			target = hit_idx_q;
		end else if (has_free) begin
			target = fill_q[IDX_W-1:0];
		end else begin
			target = old_idx_q;
		end
	end

	assign wr_entry.coord_x = req_q.coord_x;
	assign wr_entry.coord_y = req_q.coord_y;
	assign wr_entry.coord_z = req_q.coord_z;
	assign wr_entry.stamp   = req_q.frame_stamp;

	cslru_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (write_go),
		.waddr (target),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			addr_q      <= '0;
			fill_q      <= '0;
			rd_v_s1     <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			if (match) begin
				hit_q <= 1'b1;
			end
			if (write_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						addr_q  <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (write_go) begin
						if (!hit_q && has_free) begin
							fill_q <= fill_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[IDX_W-1:0];
		if ((state_q == ST_IDLE) && in_valid) begin
			req_q <= in_data;
		end
		if (match) begin
			hit_idx_q <= rd_idx_s1;
		end
		if (rd_v_s1 && ((rd_idx_s1 == '0) || (rd_entry.stamp < old_stamp_q))) begin
			old_stamp_q <= rd_entry.stamp;
			old_idx_q   <= rd_idx_s1;
		end
		if (write_go) begin
			out_data_q.slot_index   <= INDEX_W'(target);
			out_data_q.newly_placed <= !hit_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
